/* rtl/kcs_pkg.sv */
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared types and constants for the keyframe curve sampler.
// ----------------------------------------------------------------------------
package kcs_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int QUO_W      = FRAC_W + 1;   // blend fraction, 0 .. 1.0 inclusive
   localparam int CURVE_ID_W = 3;

   typedef enum logic {
      ACT_APPEND = 1'b0,
      ACT_QUERY  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_STORED  = 2'd2,
      ST_DROPPED = 2'd3
   } status_type;

   typedef struct packed {
      action_type                action;
      logic [CURVE_ID_W-1:0]     curve_id;
      logic signed [DATA_W-1:0]  time_point;
      logic signed [DATA_W-1:0]  level;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  sampled_value;
      status_type                status;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  key_time;
      logic signed [DATA_W-1:0]  key_value;
   } key_type;

endpackage

/* rtl/kcs_key_store.sv */
// ----------------------------------------------------------------------------
// kcs_key_store
// Key memory (time and value per key) and per-curve key counts.
// ----------------------------------------------------------------------------
module kcs_key_store
   import kcs_pkg::*;
#(
   parameter int NUM_CURVES     = 8,
   parameter int KEYS_PER_CURVE = 16,
   parameter int CW             = 3,
   parameter int NW             = 5,
   parameter int AW             = 7
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [CW-1:0]  cnt_rd_curve,
   output logic [NW-1:0]  cnt_rd_data,
   input  logic           cnt_wr_en,
   input  logic [CW-1:0]  cnt_wr_curve,
   input  logic [NW-1:0]  cnt_wr_data,
   input  logic           key_wr_en,
   input  logic [AW-1:0]  key_wr_addr,
   input  key_type        key_wr_data,
   input  logic [AW-1:0]  key_rd_addr,
   output key_type        key_rd_data
);

   localparam int DEPTH = NUM_CURVES * KEYS_PER_CURVE;

   key_type                key_mem [DEPTH];
   logic [NW-1:0]          cnt_mem [NUM_CURVES];
   logic [NUM_CURVES-1:0]  cnt_vld_ff;
   key_type                key_rd_ff;
   logic [NW-1:0]          cnt_rd_ff;
   logic                   cnt_hit_ff;

   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[key_wr_addr] <= key_wr_data;
      end
      key_rd_ff <= key_mem[key_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_wr_en) begin
         cnt_mem[cnt_wr_curve] <= cnt_wr_data;
      end
      cnt_rd_ff <= cnt_mem[cnt_rd_curve];
   end

   // a curve never appended to reads as zero keys
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         cnt_hit_ff <= 1'b0;
      end else begin
         if (cnt_wr_en) begin
            cnt_vld_ff[cnt_wr_curve] <= 1'b1;
         end
         cnt_hit_ff <= cnt_vld_ff[cnt_rd_curve];
      end
   end

   assign cnt_rd_data = cnt_hit_ff ? cnt_rd_ff : '0;
   assign key_rd_data = key_rd_ff;

endmodule

/* rtl/kcs_serial_div.sv */
// ----------------------------------------------------------------------------
// kcs_serial_div
// Bit-serial restoring divider for the blend fraction, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kcs_serial_div
   import kcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DATA_W-1:0]  dividend,
   input  logic [DATA_W-1:0]  divisor,
   output logic               busy,
   output logic               done,
   output logic [QUO_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(QUO_W + 1);

   logic [DATA_W-1:0]  rem_ff;
   logic [DATA_W-1:0]  div_ff;
   logic [QUO_W-1:0]   sh_ff;      // low dividend bits shift out, quotient bits shift in
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DATA_W:0]    trial;
   logic [DATA_W:0]    diff;
   logic               ge;

   // dividend is d * 2^16; the top part d >> 1 is already below the divisor
   assign trial = {rem_ff, sh_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend[DATA_W-1:1]};
         sh_ff  <= {dividend[0], {FRAC_W{1'b0}}};
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         sh_ff  <= {sh_ff[QUO_W-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule

/* rtl/kcs_serial_mul.sv */
// ----------------------------------------------------------------------------
// kcs_serial_mul
// Shift-add multiplier: value delta times fraction, one multiplier bit a cycle.
// Result is the product floored by 2^16, low 32 bits.
// ----------------------------------------------------------------------------
module kcs_serial_mul
   import kcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DATA_W:0]    mcand,
   input  logic [QUO_W-1:0]   mplier,
   output logic               busy,
   output logic               done,
   output logic [DATA_W-1:0]  scaled
);

   localparam int ACC_W  = DATA_W + 2;
   localparam int STEP_W = $clog2(QUO_W + 1);

   logic [DATA_W:0]    mcand_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [QUO_W-1:0]   plo_ff;     // multiplier bits out, product bits in
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [ACC_W-1:0]   addend;
   logic [ACC_W-1:0]   sum;

   assign addend = plo_ff[0] ? {mcand_ff[DATA_W], mcand_ff} : '0;
   assign sum    = acc_ff + addend;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // arithmetic right shift of {acc, plo} by one each step
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
         acc_ff   <= '0;
         plo_ff   <= mplier;
      end else if (busy_ff) begin
         acc_ff <= {sum[ACC_W-1], sum[ACC_W-1:1]};
         plo_ff <= {sum[0], plo_ff[QUO_W-1:1]};
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign scaled = {acc_ff[DATA_W-2:0], plo_ff[QUO_W-1]};

endmodule

/* rtl/keyframe_curve_sampler_top.sv */
// Append, or query of an empty curve: the request passes S_COUNT, then S_DONE posts
// the result. A query answered by the first key also passes S_FIRST, by the last key
// S_FIRST and S_LAST. An interpolated query reads one key a cycle in S_SCAN up to
// key i (1 .. n-1) where the scan stops, then divides and multiplies, 17 steps each.
// One item in work at a time; the next is taken the cycle after a result is posted.
// Reset clears the control state and all key counts at once; no clearing pass.
// ----------------------------------------------------------------------------
// keyframe_curve_sampler_top
// Piecewise linear keyframe curves: append keys, sample a curve at a time.
// ----------------------------------------------------------------------------
module keyframe_curve_sampler_top
   import kcs_pkg::*;
#(
   parameter int NUM_CURVES     = 8,
   parameter int KEYS_PER_CURVE = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_payload,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   localparam int CW = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
   localparam int NW = $clog2(KEYS_PER_CURVE + 1);
   localparam int IW = $clog2(KEYS_PER_CURVE);
   localparam int AW = $clog2(NUM_CURVES * KEYS_PER_CURVE);

   typedef enum logic [2:0] {
      S_IDLE, S_COUNT, S_FIRST, S_LAST, S_SCAN, S_DIV, S_MUL, S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   logic                      curve_ok_ff, curve_ok_in;
   logic [AW-1:0]             base_ff, base_in;
   logic [NW-1:0]             cnt_ff, cnt_in;
   logic [IW-1:0]             idx_ff, idx_in;
   key_type                   prev_ff, prev_in;
   logic signed [DATA_W-1:0]  last_v_ff, last_v_in;
   logic signed [DATA_W-1:0]  v0_ff, v0_in;
   logic [DATA_W:0]           dv_ff, dv_in;
   rsp_type                   res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [CW-1:0]             cnt_rd_curve;
   logic [NW-1:0]             cnt_rd_data;
   logic                      cnt_wr_en;
   logic                      key_wr_en;
   logic [AW-1:0]             key_wr_addr;
   key_type                   key_wr_data;
   logic [IW-1:0]             rd_idx;
   logic [AW-1:0]             key_rd_addr;
   key_type                   key_rd_data;

   logic                      div_start, div_busy, div_done;
   logic [QUO_W-1:0]          div_quo;
   logic [DATA_W:0]           t_ext, pt_ext, kt_ext;
   logic [DATA_W:0]           num_diff, span_diff;
   logic                      mul_start, mul_busy, mul_done;
   logic [DATA_W-1:0]         mul_out;
   logic                      t_le, t_ge, room, out_free;

   kcs_key_store #(
      .NUM_CURVES     (NUM_CURVES),
      .KEYS_PER_CURVE (KEYS_PER_CURVE),
      .CW             (CW),
      .NW             (NW),
      .AW             (AW)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .cnt_rd_curve (cnt_rd_curve),
      .cnt_rd_data  (cnt_rd_data),
      .cnt_wr_en    (cnt_wr_en),
      .cnt_wr_curve (CW'(req_ff.curve_id)),
      .cnt_wr_data  (cnt_rd_data + NW'(1)),
      .key_wr_en    (key_wr_en),
      .key_wr_addr  (key_wr_addr),
      .key_wr_data  (key_wr_data),
      .key_rd_addr  (key_rd_addr),
      .key_rd_data  (key_rd_data)
   );

   kcs_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_diff[DATA_W-1:0]),
      .divisor  (span_diff[DATA_W-1:0]),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   kcs_serial_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (dv_ff),
      .mplier (div_quo),
      .busy   (mul_busy),
      .done   (mul_done),
      .scaled (mul_out)
   );

   assign cnt_rd_curve = CW'(req_payload.curve_id);
   assign key_wr_addr  = base_ff + AW'(cnt_rd_data[IW-1:0]);
   assign key_wr_data  = '{key_time: req_ff.time_point, key_value: req_ff.level};
   assign key_rd_addr  = base_ff + AW'(rd_idx);

   assign t_ext     = {req_ff.time_point[DATA_W-1], req_ff.time_point};
   assign pt_ext    = {prev_ff.key_time[DATA_W-1], prev_ff.key_time};
   assign kt_ext    = {key_rd_data.key_time[DATA_W-1], key_rd_data.key_time};
   assign num_diff  = t_ext - pt_ext;     // positive: query lies past the earlier key
   assign span_diff = kt_ext - pt_ext;    // at least num_diff, so nonzero

   assign t_le     = $signed(req_ff.time_point) <= $signed(key_rd_data.key_time);
   assign t_ge     = $signed(req_ff.time_point) >= $signed(key_rd_data.key_time);
   assign room     = cnt_rd_data < NW'(KEYS_PER_CURVE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (state_ff)
         S_COUNT: rd_idx = '0;
         S_FIRST: rd_idx = IW'(cnt_ff - NW'(1));
         S_LAST:  rd_idx = IW'(1);
         S_SCAN:  rd_idx = idx_ff + IW'(1);
         default: rd_idx = '0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      curve_ok_in = curve_ok_ff;
      base_in     = base_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      prev_in     = prev_ff;
      last_v_in   = last_v_ff;
      v0_in       = v0_ff;
      dv_in       = dv_ff;
      res_in      = res_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cnt_wr_en   = 1'b0;
      key_wr_en   = 1'b0;
      div_start   = 1'b0;
      mul_start   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_payload;
               curve_ok_in = int'(req_payload.curve_id) < NUM_CURVES;
               base_in     = AW'(CW'(req_payload.curve_id)) * AW'(KEYS_PER_CURVE);
               state_in    = S_COUNT;
            end
         end
         S_COUNT: begin
            cnt_in = cnt_rd_data;
            res_in.sampled_value = '0;
            if (req_ff.action == ACT_APPEND) begin
               if (curve_ok_ff && room) begin
                  key_wr_en     = 1'b1;
                  cnt_wr_en     = 1'b1;
                  res_in.status = ST_STORED;
               end else begin
                  res_in.status = ST_DROPPED;
               end
               state_in = S_DONE;
            end else if (!curve_ok_ff || cnt_rd_data == '0) begin
               res_in.status = ST_EMPTY;
               state_in      = S_DONE;
            end else begin
               res_in.status = ST_OK;
               state_in      = S_FIRST;
            end
         end
         S_FIRST: begin
            prev_in = key_rd_data;
            if (t_le) begin
               res_in.sampled_value = key_rd_data.key_value;
               state_in = S_DONE;
            end else begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            last_v_in = key_rd_data.key_value;
            idx_in    = IW'(1);
            if (t_ge) begin
               res_in.sampled_value = key_rd_data.key_value;
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (t_le) begin
               div_start = 1'b1;
               v0_in     = prev_ff.key_value;
               dv_in     = {key_rd_data.key_value[DATA_W-1], key_rd_data.key_value}
                         - {prev_ff.key_value[DATA_W-1], prev_ff.key_value};
               state_in  = S_DIV;
            end else if (NW'(idx_ff) == cnt_ff - NW'(1)) begin
               res_in.sampled_value = last_v_ff;
               state_in = S_DONE;
            end else begin
               prev_in = key_rd_data;
               idx_in  = idx_ff + IW'(1);
            end
         end
         S_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               res_in.sampled_value = v0_ff + mul_out;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      curve_ok_ff <= curve_ok_in;
      base_ff     <= base_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      prev_ff     <= prev_in;
      last_v_ff   <= last_v_in;
      v0_ff       <= v0_in;
      dv_ff       <= dv_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in work");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_busy && mul_busy))
      else $error("divider and multiplier busy together");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (NW'(idx_ff) < cnt_ff))
      else $error("scan index past key count");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide step");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      key_wr_en |-> (curve_ok_ff && req_ff.action == ACT_APPEND))
      else $error("key written for a bad curve or a query");

endmodule
